// ----- hw/rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CURSOR_ROW_W = 5;
   localparam int CURSOR_COL_W = 7;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int BG_W         = 3;
   localparam int CELL_W       = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] LINE_FEED       = 8'h0A;
   localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'h0D;
   localparam logic [CHAR_W-1:0] SPACE_CHAR      = 8'h20;
   localparam logic [ATTR_W-1:0] KEEP_MASK       = 8'h8F;
   localparam logic [ATTR_W-1:0] ATTR_RESET      = 8'h0F;

   // register word index on the csr port
   localparam logic REG_ATTRIBUTE = 1'b0;

   typedef enum logic [1:0] {
      REQ_PUT,
      REQ_CLEAR,
      REQ_BACKGROUND,
      REQ_READ
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SW_INIT,
      SW_COPY,
      SW_CLEAR,
      SW_BACKGROUND
   } sweep_type;

   typedef struct packed {
      logic write_cell;
      logic scroll;
   } put_ctl_type;

endpackage

// ----- hw/rtl/tcw_cursor_step.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor_step
// Next cursor position for a put request, with cell write and scroll flags.
// ----------------------------------------------------------------------------
module tcw_cursor_step #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic [$clog2(ROWS)-1:0]      row,
   input  logic [$clog2(COLS)-1:0]      col,
   input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
   output logic [$clog2(ROWS)-1:0]      row_next,
   output logic [$clog2(COLS)-1:0]      col_next,
   output tcw_pkg::put_ctl_type         ctl
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);

   logic [RW:0] row_t;
   logic [CW:0] col_t;

   always_comb begin
      row_t          = {1'b0, row};
      col_t          = {1'b0, col};
      ctl.write_cell = 1'b0;
      ctl.scroll     = 1'b0;
      if (char_code == tcw_pkg::LINE_FEED) begin
         row_t = row_t + (RW+1)'(1);
         col_t = '0;
      end else if (char_code == tcw_pkg::CARRIAGE_RETURN) begin
         col_t = '0;
      end else begin
         ctl.write_cell = 1'b1;
         col_t          = col_t + (CW+1)'(1);
      end
      if (col_t == (CW+1)'(COLS)) begin
         col_t = '0;
         row_t = row_t + (RW+1)'(1);
      end
      if (row_t == (RW+1)'(ROWS)) begin
         row_t      = (RW+1)'(ROWS - 1);
         ctl.scroll = 1'b1;
      end
      row_next = row_t[RW-1:0];
      col_next = col_t[CW-1:0];
   end

endmodule

// ----- hw/rtl/text_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console with an internal ROWS x COLS cell buffer in one memory.
// ----------------------------------------------------------------------------
// Put without scroll: accept, ST_DONE, response register. Read cell: accept,
// ST_READ, ST_DONE, response register. Scroll, clear and set-background walk
// the cell memory one entry per cycle in ST_SWEEP, then ST_DRAIN; the single
// write port of the cell memory sets this rate. One request in flight; the
// next is taken while the result waits.
// Reset: a clearing pass zeroes the memory, req_tready stays low meanwhile;
// cursor goes to 0,0 and attribute to 0x0F.
module text_console_writer_unit #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code, background, read_row, read_column
   input  logic [1:0]  req_tuser,   // req_type
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_row, cursor_column, scrolled,
                                    // cell_char, cell_attribute
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int RW   = $clog2(ROWS);
   localparam int CW   = $clog2(COLS);
   localparam int CELL = ROWS * COLS;
   localparam int AW   = $clog2(CELL);
   localparam int DW   = tcw_pkg::CELL_W;
   localparam logic [AW-1:0] COLS_A = AW'(COLS);
   localparam logic [AW-1:0] LAST_A = AW'(CELL - 1);
   localparam logic [AW-1:0] BOT_A  = AW'(CELL - COLS);

   // request fields
   logic [7:0] req_char_code;
   logic [2:0] req_background;
   logic [4:0] req_read_row;
   logic [6:0] req_read_column;

   assign req_char_code   = req_tdata[7:0];
   assign req_background  = req_tdata[10:8];
   assign req_read_row    = req_tdata[15:11];
   assign req_read_column = req_tdata[22:16];

   // control state
   tcw_pkg::state_type state_ff, state_in;
   tcw_pkg::sweep_type kind_ff, kind_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [7:0]         attr_ff, attr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [AW-1:0]  pend_addr_ff, pend_addr_in;
   logic           pend_zero_ff, pend_zero_in;
   logic [2:0]     bg_ff, bg_in;
   logic           rd_ok_ff, rd_ok_in;
   logic           scrolled_ff, scrolled_in;
   logic [7:0]     cchar_ff, cchar_in;
   logic [7:0]     cattr_ff, cattr_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;

   // memory ports
   logic [DW-1:0]  mem [CELL];
   logic [DW-1:0]  rdata_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [DW-1:0]  wr_data;
   logic [DW-1:0]  sweep_data;
   logic [7:0]     bg_attr;

   // cursor step
   logic [RW-1:0]         put_row;
   logic [CW-1:0]         put_col;
   tcw_pkg::put_ctl_type  put_ctl;
   logic [AW-1:0]         cur_addr;
   logic [AW-1:0]         req_addr;
   logic                  req_in_range;
   logic                  rsp_load;

   tcw_cursor_step #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_cursor (
      .row       (row_ff),
      .col       (col_ff),
      .char_code (req_char_code),
      .row_next  (put_row),
      .col_next  (put_col),
      .ctl       (put_ctl)
   );

   assign cur_addr     = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign req_addr     = AW'(req_read_row) * COLS_A + AW'(req_read_column);
   assign req_in_range = (32'(req_read_row) < 32'(ROWS)) &&
                         (32'(req_read_column) < 32'(COLS));

   assign bg_attr = (rdata_ff[15:8] & tcw_pkg::KEEP_MASK) | {1'b0, bg_ff, 4'b0000};

   always_comb begin
      case (kind_ff)
         tcw_pkg::SW_INIT:       sweep_data = '0;
         tcw_pkg::SW_COPY:       sweep_data = pend_zero_ff ? '0 : rdata_ff;
         tcw_pkg::SW_CLEAR:      sweep_data = {rdata_ff[15:8], tcw_pkg::SPACE_CHAR};
         tcw_pkg::SW_BACKGROUND: sweep_data = {bg_attr, rdata_ff[7:0]};
         default:                sweep_data = '0;
      endcase
   end

   assign rsp_load = (state_ff == tcw_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = cnt_ff;
      pend_zero_in  = 1'b0;
      row_in        = row_ff;
      col_in        = col_ff;
      attr_in       = attr_ff;
      bg_in         = bg_ff;
      rd_ok_in      = rd_ok_ff;
      scrolled_in   = scrolled_ff;
      cchar_in      = cchar_ff;
      cattr_in      = cattr_ff;
      rd_addr       = cnt_ff;
      wr_en         = pend_valid_ff;
      wr_addr       = pend_addr_ff;
      wr_data       = sweep_data;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[2] == tcw_pkg::REG_ATTRIBUTE) begin
         attr_in = csr_pwdata[7:0];
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, cattr_ff, cchar_ff, scrolled_ff,
                         tcw_pkg::CURSOR_COL_W'(col_ff), tcw_pkg::CURSOR_ROW_W'(row_ff)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tcw_pkg::ST_INIT: begin
            pend_valid_in = 1'b1;
            cnt_in        = cnt_ff + AW'(1);
            if (cnt_ff == LAST_A) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_IDLE: begin
            rd_addr = req_addr;
            if (req_tvalid) begin
               scrolled_in = 1'b0;
               cchar_in    = '0;
               cattr_in    = '0;
               cnt_in      = '0;
               state_in    = tcw_pkg::ST_DONE;
               case (tcw_pkg::req_kind_type'(req_tuser))
                  tcw_pkg::REQ_PUT: begin
                     wr_en   = put_ctl.write_cell;
                     wr_addr = cur_addr;
                     wr_data = {attr_ff, req_char_code};
                     row_in  = put_row;
                     col_in  = put_col;
                     if (put_ctl.scroll) begin
                        scrolled_in = 1'b1;
                        kind_in     = tcw_pkg::SW_COPY;
                        state_in    = tcw_pkg::ST_SWEEP;
                     end
                  end
                  tcw_pkg::REQ_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     kind_in  = tcw_pkg::SW_CLEAR;
                     state_in = tcw_pkg::ST_SWEEP;
                  end
                  tcw_pkg::REQ_BACKGROUND: begin
                     bg_in    = req_background;
                     kind_in  = tcw_pkg::SW_BACKGROUND;
                     state_in = tcw_pkg::ST_SWEEP;
                  end
                  tcw_pkg::REQ_READ: begin
                     rd_ok_in = req_in_range;
                     state_in = tcw_pkg::ST_READ;
                  end
                  default: begin
                     state_in = tcw_pkg::ST_DONE;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            if (rd_ok_ff) begin
               cchar_in = rdata_ff[7:0];
               cattr_in = rdata_ff[15:8];
            end
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_SWEEP: begin
            pend_valid_in = 1'b1;
            pend_zero_in  = (kind_ff == tcw_pkg::SW_COPY) && (cnt_ff >= BOT_A);
            if (kind_ff == tcw_pkg::SW_COPY && cnt_ff < BOT_A) begin
               rd_addr = cnt_ff + COLS_A;
            end
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == LAST_A) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            state_in = (kind_ff == tcw_pkg::SW_INIT) ? tcw_pkg::ST_IDLE
                                                     : tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_INIT;
         kind_ff       <= tcw_pkg::SW_INIT;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         attr_ff       <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kind_ff       <= kind_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         attr_ff       <= attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_zero_ff <= pend_zero_in;
      bg_ff        <= bg_in;
      rd_ok_ff     <= rd_ok_in;
      scrolled_ff  <= scrolled_in;
      cchar_ff     <= cchar_in;
      cattr_ff     <= cattr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // cell memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == tcw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tcw_pkg::REG_ATTRIBUTE) ? {24'h000000, attr_ff}
                                                                 : 32'h00000000;

`ifndef SYNTH
   a_pend_in_sweep : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == tcw_pkg::ST_SWEEP || state_ff == tcw_pkg::ST_DRAIN ||
                         state_ff == tcw_pkg::ST_INIT))
      else $error("pending write outside a sweep");

   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) < 32'(COLS)))
      else $error("cursor out of range");

   a_scroll_bottom : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && scrolled_ff) |-> (32'(row_ff) == 32'(ROWS - 1)))
      else $error("scroll result not on last row");

   a_read_result_follows_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_READ) |=> (state_ff == tcw_pkg::ST_DONE))
      else $error("read did not complete");
`endif

endmodule
